### hdl/thp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_pkg: shared types and constants of the theme header parser
// Event codes, status codes, the event record passed from the parsing
// front end to the output stage, and the resource slot mapping.
// ----------------------------------------------------------------------------
package thp_pkg;

  localparam int KIND_W   = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int SLOT_W   = 2;
  localparam int STATUS_W = 2;
  localparam int SUM_W    = 16;

  // Event kinds
  localparam logic [KIND_W-1:0] EV_SIZE  = 3'd0;
  localparam logic [KIND_W-1:0] EV_TYPE  = 3'd1;
  localparam logic [KIND_W-1:0] EV_CHAR  = 3'd2;
  localparam logic [KIND_W-1:0] EV_END   = 3'd3;
  localparam logic [KIND_W-1:0] EV_DONE  = 3'd4;
  localparam logic [KIND_W-1:0] EV_ERROR = 3'd5;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_VERSION = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BAD_COUNT   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_SUM     = 2'd3;

  // Resource slots
  localparam logic [SLOT_W-1:0] SLOT_DESKTOP     = 2'd0;
  localparam logic [SLOT_W-1:0] SLOT_SCREENSAVER = 2'd1;
  localparam logic [SLOT_W-1:0] SLOT_RINGTONE    = 2'd2;
  localparam logic [SLOT_W-1:0] SLOT_NONE        = 2'd3;

  // Header constants
  localparam logic [7:0] HDR_VERSION   = 8'h10;
  localparam logic [7:0] HDR_MAX_COUNT = 8'h7F;
  localparam int         SIG_BYTES     = 3;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  index;
    logic [VALUE_W-1:0]  value;
    logic [STATUS_W-1:0] status;
    logic [SUM_W-1:0]    sum;
  } evt_t;

  localparam int EVT_W = $bits(evt_t);

  function automatic logic [SLOT_W-1:0] type_slot(input logic [7:0] type_byte);
    logic [SLOT_W-1:0] slot;
    case (type_byte)
      8'd0:    slot = SLOT_DESKTOP;
      8'd1:    slot = SLOT_SCREENSAVER;
      8'd2:    slot = SLOT_RINGTONE;
      default: slot = SLOT_NONE;
    endcase
    return slot;
  endfunction

endpackage

### hdl/thp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_front: header byte parser
// Takes one byte per cycle while the queue has room, tracks the header layout
// and the running byte sum, and produces at most one event record per byte.
// ----------------------------------------------------------------------------
module thp_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  input  logic               queue_full,
  input  logic [7:0]         data_byte,
  input  logic               start_of_file,
  output logic               byte_ready,
  output logic               evt_push,
  output thp_pkg::evt_t      evt
);
  import thp_pkg::*;

  localparam logic [3:0] PH_WAIT    = 4'd0;
  localparam logic [3:0] PH_SIG     = 4'd1;
  localparam logic [3:0] PH_VERSION = 4'd2;
  localparam logic [3:0] PH_COUNT   = 4'd3;
  localparam logic [3:0] PH_SIZE    = 4'd4;
  localparam logic [3:0] PH_TYPE    = 4'd5;
  localparam logic [3:0] PH_NAME    = 4'd6;
  localparam logic [3:0] PH_CSUM    = 4'd7;
  localparam logic [3:0] PH_DONE    = 4'd8;

  logic [3:0]         phase, phase_next, phase_eff;
  logic [1:0]         field_cnt, field_cnt_next, field_cnt_eff;
  logic [INDEX_W-1:0] cur_entry, cur_entry_next, cur_entry_eff;
  logic [INDEX_W-1:0] entry_total, entry_total_next, entry_total_eff;
  logic [31:0]        size_acc, size_acc_next, size_acc_eff, size_shift;
  logic [SUM_W-1:0]   byte_sum, byte_sum_next, byte_sum_eff;
  logic [7:0]         sum_high, sum_high_next;
  logic               name_half, name_half_next, name_half_eff;
  logic               error_latched, error_next, error_eff;
  logic               accept, active, last_entry;
  logic [15:0]        stored_word;

  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  // A start byte wipes the parser before the byte itself is processed.
  assign phase_eff       = start_of_file ? PH_SIG : phase;
  assign field_cnt_eff   = start_of_file ? 2'd0 : field_cnt;
  assign cur_entry_eff   = start_of_file ? '0 : cur_entry;
  assign entry_total_eff = start_of_file ? '0 : entry_total;
  assign size_acc_eff    = start_of_file ? '0 : size_acc;
  assign byte_sum_eff    = start_of_file ? '0 : byte_sum;
  assign name_half_eff   = start_of_file ? 1'b0 : name_half;
  assign error_eff       = start_of_file ? 1'b0 : error_latched;

  assign active = !error_eff && (phase_eff != PH_WAIT) && (phase_eff != PH_DONE);
  assign last_entry  = ({1'b0, cur_entry_eff} + 8'd1) >= {1'b0, entry_total_eff};
  assign size_shift  = {size_acc_eff[23:0], data_byte};
  assign stored_word = {sum_high, data_byte};

  always_comb begin
    phase_next       = phase_eff;
    field_cnt_next   = field_cnt_eff;
    cur_entry_next   = cur_entry_eff;
    entry_total_next = entry_total_eff;
    size_acc_next    = size_acc_eff;
    byte_sum_next    = byte_sum_eff;
    sum_high_next    = start_of_file ? 8'd0 : sum_high;
    name_half_next   = name_half_eff;
    error_next       = error_eff;
    evt_push         = 1'b0;
    evt.kind         = EV_SIZE;
    evt.index        = cur_entry_eff;
    evt.value        = '0;
    evt.status       = ST_OK;

    if (active && phase_eff != PH_CSUM) begin
      byte_sum_next = byte_sum_eff + SUM_W'(data_byte);
    end

    if (active) begin
      unique case (phase_eff)
        PH_SIG: begin
          if (field_cnt_eff == 2'(SIG_BYTES - 1)) begin
            field_cnt_next = 2'd0;
            phase_next     = PH_VERSION;
          end else begin
            field_cnt_next = field_cnt_eff + 2'd1;
          end
        end
        PH_VERSION: begin
          if (data_byte != HDR_VERSION) begin
            error_next = 1'b1;
            phase_next = PH_WAIT;
            evt_push   = 1'b1;
            evt.kind   = EV_ERROR;
            evt.index  = '0;
            evt.value  = 32'(data_byte);
            evt.status = ST_BAD_VERSION;
          end else begin
            phase_next = PH_COUNT;
          end
        end
        PH_COUNT: begin
          if (data_byte > HDR_MAX_COUNT) begin
            error_next = 1'b1;
            phase_next = PH_WAIT;
            evt_push   = 1'b1;
            evt.kind   = EV_ERROR;
            evt.index  = '0;
            evt.value  = 32'(data_byte);
            evt.status = ST_BAD_COUNT;
          end else begin
            entry_total_next = data_byte[INDEX_W-1:0];
            cur_entry_next   = '0;
            field_cnt_next   = 2'd0;
            size_acc_next    = '0;
            phase_next       = (data_byte == 8'd0) ? PH_CSUM : PH_SIZE;
          end
        end
        PH_SIZE: begin
          if (field_cnt_eff != 2'd3) begin
            field_cnt_next = field_cnt_eff + 2'd1;
            size_acc_next  = size_shift;
          end else begin
            field_cnt_next = 2'd0;
            size_acc_next  = '0;
            if (last_entry) begin
              cur_entry_next = '0;
              phase_next     = PH_TYPE;
            end else begin
              cur_entry_next = cur_entry_eff + 1'b1;
            end
            evt_push  = 1'b1;
            evt.kind  = EV_SIZE;
            evt.value = size_shift;
          end
        end
        PH_TYPE: begin
          name_half_next = 1'b0;
          phase_next     = PH_NAME;
          evt_push       = 1'b1;
          evt.kind       = EV_TYPE;
          evt.value      = 32'(data_byte);
        end
        PH_NAME: begin
          if (!name_half_eff) begin
            name_half_next = 1'b1;
          end else begin
            name_half_next = 1'b0;
            evt_push       = 1'b1;
            if (data_byte != 8'd0) begin
              evt.kind  = EV_CHAR;
              evt.value = 32'(data_byte);
            end else begin
              evt.kind = EV_END;
              if (last_entry) begin
                cur_entry_next = '0;
                field_cnt_next = 2'd0;
                phase_next     = PH_CSUM;
              end else begin
                cur_entry_next = cur_entry_eff + 1'b1;
                phase_next     = PH_TYPE;
              end
            end
          end
        end
        PH_CSUM: begin
          if (field_cnt_eff == 2'd0) begin
            sum_high_next  = data_byte;
            field_cnt_next = 2'd1;
          end else begin
            field_cnt_next = 2'd0;
            evt_push       = 1'b1;
            evt.index      = '0;
            evt.value      = 32'(stored_word);
            if (stored_word != byte_sum_eff) begin
              error_next = 1'b1;
              phase_next = PH_WAIT;
              evt.kind   = EV_ERROR;
              evt.status = ST_BAD_SUM;
            end else begin
              phase_next = PH_DONE;
              evt.kind   = EV_DONE;
            end
          end
        end
        default: begin
          phase_next = PH_WAIT;
        end
      endcase
    end
    evt.sum = byte_sum_next;
    evt_push = evt_push && accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_WAIT;
      field_cnt     <= 2'd0;
      cur_entry     <= '0;
      entry_total   <= '0;
      size_acc      <= '0;
      byte_sum      <= '0;
      sum_high      <= 8'd0;
      name_half     <= 1'b0;
      error_latched <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      field_cnt     <= field_cnt_next;
      cur_entry     <= cur_entry_next;
      entry_total   <= entry_total_next;
      size_acc      <= size_acc_next;
      byte_sum      <= byte_sum_next;
      sum_high      <= sum_high_next;
      name_half     <= name_half_next;
      error_latched <= error_next;
    end
  end

  a_error_latches: assert property (@(posedge clk) disable iff (rst)
    evt_push && evt.kind == EV_ERROR |=> error_latched)
    else $error("error event did not latch the error flag");

  a_quiet_after_error: assert property (@(posedge clk) disable iff (rst)
    error_latched && !start_of_file |-> !evt_push)
    else $error("event produced while an error is latched");

  a_entry_in_range: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_SIZE || phase == PH_TYPE || phase == PH_NAME) && !error_latched
      |-> cur_entry < entry_total)
    else $error("entry index ran past the entry count");

endmodule

### hdl/thp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_queue: event queue between parser and output stage
// Small first-in first-out buffer of event records, so that the parser and
// the output side stall independently.
// ----------------------------------------------------------------------------
module thp_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  thp_pkg::evt_t push_evt,
  input  logic          pop,
  output logic          full,
  output logic          not_empty,
  output thp_pkg::evt_t head_evt
);
  import thp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  evt_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head_evt  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_evt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("pop from an empty queue");

  a_count_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count lost a push");

endmodule

### hdl/thp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thp_back: event output stage
// Pulls event records from the queue, maps type bytes to resource slots and
// holds the formatted result in the output register.
// ----------------------------------------------------------------------------
module thp_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          head_valid,
  input  thp_pkg::evt_t head_evt,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_kind,
  output logic [63:0]   out_data
);
  import thp_pkg::*;

  logic [SLOT_W-1:0] slot;
  logic [2:0]        kind_reg;
  logic [63:0]       data_reg;

  assign pop  = head_valid && (!out_valid || out_ready);
  assign slot = (head_evt.kind == EV_TYPE) ? type_slot(head_evt.value[7:0]) : SLOT_NONE;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      kind_reg <= head_evt.kind;
      data_reg <= {5'd0, head_evt.sum, head_evt.status, slot, head_evt.value,
                   head_evt.index};
    end
  end

  assign out_kind = kind_reg;
  assign out_data = data_reg;

endmodule

### hdl/theme_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// theme_header_parser: streaming parser for a theme container header
// Top level: parser front end, event queue and output register.
// ----------------------------------------------------------------------------
// The block takes one header byte per cycle and produces at most one event
// per byte; with a ready sink it sustains one byte every clock. An event
// is written into the event queue when its byte is accepted and is then
// loaded into the output register once that register is free. The input
// stalls only when the event queue of QUEUE_DEPTH records is full because
// the sink holds off.
// Bytes before the first start flag, after an error and after the header
// done event produce nothing until the next start flag.
module theme_header_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] start_of_file
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [6:0] entry_index, [38:7] event_value,
                                 // [40:39] resource_slot, [42:41] status_code,
                                 // [58:43] computed_sum, [63:59] zero
  output logic [2:0]  m_tuser    // [2:0] event_kind
);
  import thp_pkg::*;

  logic queue_full, queue_not_empty, evt_push, evt_pop;
  evt_t push_evt, head_evt;

  thp_front u_front (
    .clk           (clk),
    .rst           (rst),
    .byte_valid    (s_tvalid),
    .queue_full    (queue_full),
    .data_byte     (s_tdata),
    .start_of_file (s_tuser),
    .byte_ready    (s_tready),
    .evt_push      (evt_push),
    .evt           (push_evt)
  );

  thp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (evt_push),
    .push_evt  (push_evt),
    .pop       (evt_pop),
    .full      (queue_full),
    .not_empty (queue_not_empty),
    .head_evt  (head_evt)
  );

  thp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (queue_not_empty),
    .head_evt   (head_evt),
    .pop        (evt_pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_kind   (m_tuser),
    .out_data   (m_tdata)
  );

endmodule

### dv/tb_theme_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_theme_header_parser: self-checking bench for the theme header parser
// Drives header byte streams (directed cases, then random headers with
// faults, restarts and noise) through the input stream, predicts every
// event cycle-independently and compares each output transaction in order.
// ----------------------------------------------------------------------------
module tb_theme_header_parser;
  import thp_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;

  typedef enum logic [3:0] {
    P_WAIT, P_SIG, P_VERSION, P_COUNT, P_SIZE, P_TYPE, P_NAME, P_CHECK, P_DONE
  } parse_state_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [INDEX_W-1:0]  entry;
    logic [VALUE_W-1:0]  value;
    logic [SLOT_W-1:0]   slot;
    logic [STATUS_W-1:0] status;
    logic [SUM_W-1:0]    sum;
  } header_event_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;

  theme_header_parser uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predicted parser state.
  parse_state_t        p_state = P_WAIT;
  logic [1:0]          p_cnt = '0;
  logic [INDEX_W-1:0]  p_entry = '0;
  logic [INDEX_W-1:0]  p_total = '0;
  logic [31:0]         p_acc = '0;
  logic [SUM_W-1:0]    p_sum = '0;
  logic [7:0]          p_sum_hi = '0;
  logic                p_half = 1'b0;
  logic                p_err = 1'b0;

  header_event_t pending_events[$];
  logic [7:0]    hdr_q[$];
  logic [15:0]   hdr_sum;

  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int fail_cnt = 0;
  int live_bytes = 0;
  int headers_sent = 0;
  int events_seen = 0;
  int kind_seen[6];
  int cycle_cnt = 0;

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycle_cnt);
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= rst ? 1'b0 : ($urandom_range(99) >= snk_stall_pct);
  end

  function automatic header_event_t make_event(input logic [KIND_W-1:0] kind,
                                               input logic [INDEX_W-1:0] entry,
                                               input logic [31:0] value,
                                               input logic [SLOT_W-1:0] slot,
                                               input logic [STATUS_W-1:0] status);
    header_event_t ev;
    ev.kind = kind;
    ev.entry = entry;
    ev.value = value;
    ev.slot = slot;
    ev.status = status;
    ev.sum = p_sum;
    return ev;
  endfunction

  task automatic flag_error(input logic [31:0] value, input logic [STATUS_W-1:0] code,
                            output header_event_t ev);
    p_err = 1'b1;
    p_state = P_WAIT;
    ev = make_event(EV_ERROR, '0, value, SLOT_NONE, code);
  endtask

  // Advances the predicted parser by one byte; live is set when the byte was
  // not ignored, has_event when it produces an event.
  task automatic predict_header_byte(input logic [7:0] b, input logic sof,
                                     output bit live, output bit has_event,
                                     output header_event_t ev);
    logic [INDEX_W-1:0] idx;
    logic [15:0]        word;
    live = 1'b0;
    has_event = 1'b0;
    ev = '0;
    if (sof) begin
      p_state = P_SIG;
      p_cnt = '0;
      p_entry = '0;
      p_total = '0;
      p_acc = '0;
      p_sum = '0;
      p_sum_hi = '0;
      p_half = 1'b0;
      p_err = 1'b0;
    end
    if (!p_err && p_state != P_WAIT && p_state != P_DONE) begin
      live = 1'b1;
      if (p_state != P_CHECK) p_sum = p_sum + 16'(b);
      idx = p_entry;
      case (p_state)
        P_SIG: begin
          p_cnt = p_cnt + 2'd1;
          if (p_cnt == SIG_BYTES) begin
            p_cnt = '0;
            p_state = P_VERSION;
          end
        end
        P_VERSION: begin
          if (b != HDR_VERSION) begin
            flag_error({24'd0, b}, ST_BAD_VERSION, ev);
            has_event = 1'b1;
          end else begin
            p_state = P_COUNT;
          end
        end
        P_COUNT: begin
          if (b > HDR_MAX_COUNT) begin
            flag_error({24'd0, b}, ST_BAD_COUNT, ev);
            has_event = 1'b1;
          end else begin
            p_total = b[INDEX_W-1:0];
            p_entry = '0;
            p_cnt = '0;
            p_acc = '0;
            p_state = (b == 8'd0) ? P_CHECK : P_SIZE;
          end
        end
        P_SIZE: begin
          p_acc = {p_acc[23:0], b};
          if (p_cnt != 2'd3) begin
            p_cnt = p_cnt + 2'd1;
          end else begin
            p_cnt = '0;
            if (int'(p_entry) + 1 >= int'(p_total)) begin
              p_entry = '0;
              p_state = P_TYPE;
            end else begin
              p_entry = p_entry + 1'b1;
            end
            ev = make_event(EV_SIZE, idx, p_acc, SLOT_NONE, ST_OK);
            has_event = 1'b1;
            p_acc = '0;
          end
        end
        P_TYPE: begin
          p_half = 1'b0;
          p_state = P_NAME;
          ev = make_event(EV_TYPE, p_entry, {24'd0, b},
                          (b <= 8'd2) ? b[SLOT_W-1:0] : SLOT_NONE, ST_OK);
          has_event = 1'b1;
        end
        P_NAME: begin
          if (!p_half) begin
            p_half = 1'b1;
          end else begin
            p_half = 1'b0;
            has_event = 1'b1;
            if (b != 8'd0) begin
              ev = make_event(EV_CHAR, idx, {24'd0, b}, SLOT_NONE, ST_OK);
            end else begin
              if (int'(p_entry) + 1 >= int'(p_total)) begin
                p_entry = '0;
                p_cnt = '0;
                p_state = P_CHECK;
              end else begin
                p_entry = p_entry + 1'b1;
                p_state = P_TYPE;
              end
              ev = make_event(EV_END, idx, '0, SLOT_NONE, ST_OK);
            end
          end
        end
        P_CHECK: begin
          if (p_cnt == 2'd0) begin
            p_sum_hi = b;
            p_cnt = 2'd1;
          end else begin
            p_cnt = '0;
            word = {p_sum_hi, b};
            has_event = 1'b1;
            if (word != p_sum) begin
              flag_error({16'd0, word}, ST_BAD_SUM, ev);
            end else begin
              p_state = P_DONE;
              ev = make_event(EV_DONE, '0, {16'd0, word}, SLOT_NONE, ST_OK);
            end
          end
        end
        default: p_state = P_WAIT;
      endcase
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back bytes never drop it.
  task automatic send_byte(input logic [7:0] b, input logic sof);
    bit            live;
    bit            has_event;
    header_event_t ev;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tuser <= sof;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_header_byte(b, sof, live, has_event, ev);
    if (has_event) pending_events.push_back(ev);
    if (live) live_bytes++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(negedge clk);
    // Bytes without an event may still be in flight.
    repeat (4) @(negedge clk);
  endtask

  task automatic add_byte(input logic [7:0] b);
    hdr_q.push_back(b);
    hdr_sum = hdr_sum + 16'(b);
  endtask

  task automatic send_stream();
    foreach (hdr_q[i]) send_byte(hdr_q[i], i == 0);
    headers_sent++;
  endtask

  // Builds a header of n entries in hdr_q. With faults set, the version,
  // the count and the checksum are sometimes corrupted and the header is
  // sometimes cut short, so that the next start lands inside it.
  task automatic make_header(input int n, input int max_name, input bit faults);
    int          units;
    int          keep;
    logic [15:0] word;
    hdr_q.delete();
    hdr_sum = '0;
    repeat (SIG_BYTES) add_byte(8'($urandom_range(255)));
    add_byte((faults && $urandom_range(19) == 0) ? 8'($urandom_range(255)) : HDR_VERSION);
    add_byte((faults && $urandom_range(19) == 0) ? 8'($urandom_range(128, 255)) : 8'(n));
    repeat (n) begin
      case ($urandom_range(7))
        0: repeat (4) add_byte(8'hFF);
        1: repeat (4) add_byte(8'h00);
        default: repeat (4) add_byte(8'($urandom_range(255)));
      endcase
    end
    repeat (n) begin
      add_byte($urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(255)));
      units = $urandom_range(max_name);
      repeat (units) begin
        add_byte(8'($urandom_range(255)));
        add_byte(8'($urandom_range(1, 255)));
      end
      add_byte(8'($urandom_range(255)));
      add_byte(8'h00);
    end
    word = hdr_sum;
    if (faults && $urandom_range(9) == 0) word = word ^ (16'd1 << $urandom_range(15));
    hdr_q.push_back(word[15:8]);
    hdr_q.push_back(word[7:0]);
    if (faults && $urandom_range(14) == 0) begin
      keep = $urandom_range(1, hdr_q.size() - 1);
      while (hdr_q.size() > keep) void'(hdr_q.pop_back());
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("tb: mismatch in %s at cycle %0d: expected %0h, got %0h",
                 what, cycle_cnt, want, got);
    end
  endtask

  always @(posedge clk) begin : check_events
    header_event_t want;
    if (!rst && m_tvalid && m_tready) begin
      events_seen++;
      if (m_tuser < 3'd6) kind_seen[m_tuser]++;
      if (pending_events.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("tb: unexpected event kind %0d data %0h at cycle %0d",
                   m_tuser, m_tdata, cycle_cnt);
      end else begin
        want = pending_events.pop_front();
        check_field("event_kind", 32'(want.kind), 32'(m_tuser));
        check_field("entry_index", 32'(want.entry), 32'(m_tdata[6:0]));
        check_field("event_value", want.value, m_tdata[38:7]);
        check_field("resource_slot", 32'(want.slot), 32'(m_tdata[40:39]));
        check_field("status_code", 32'(want.status), 32'(m_tdata[42:41]));
        check_field("computed_sum", 32'(want.sum), 32'(m_tdata[58:43]));
        check_field("tdata padding", 32'd0, 32'(m_tdata[63:59]));
      end
    end
  end

  task automatic test_before_start();
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
  endtask

  task automatic test_version_error();
    send_byte(8'h4D, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hEF, 1'b0);
    // Ignored: the error holds until the next start.
    send_byte(HDR_VERSION, 1'b0);
  endtask

  task automatic test_count_error();
    send_byte(8'h01, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(HDR_VERSION, 1'b0);
    send_byte(8'h80, 1'b0);
  endtask

  task automatic test_single_entry();
    hdr_q.delete();
    hdr_sum = '0;
    add_byte(8'hA5);
    add_byte(8'h00);
    add_byte(8'hFF);
    add_byte(HDR_VERSION);
    add_byte(8'h01);
    repeat (4) add_byte(8'hFF);
    add_byte(8'h02);
    add_byte(8'hFF);
    add_byte(8'hFF);
    add_byte(8'h00);
    add_byte(8'h00);
    hdr_q.push_back(hdr_sum[15:8]);
    hdr_q.push_back(hdr_sum[7:0]);
    foreach (hdr_q[i]) begin
      send_byte(hdr_q[i], i == 0);
      // Hold the stream mid-header until the size event has drained.
      if (i == 8) wait_drained();
    end
    headers_sent++;
    send_byte(8'h5A, 1'b0);
    wait_drained();
  endtask

  task automatic test_max_entries();
    make_header(int'(HDR_MAX_COUNT), 0, 1'b0);
    send_stream();
    wait_drained();
  endtask

  task automatic test_random_headers(input int src_pct, input int snk_pct,
                                     input int n_live);
    int stop_at;
    int n;
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    stop_at = live_bytes + n_live;
    while (live_bytes < stop_at) begin
      if ($urandom_range(3) == 0) n = $urandom_range(4, 12);
      else n = $urandom_range(0, 3);
      make_header(n, 4, 1'b1);
      send_stream();
      if ($urandom_range(9) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(255)), 1'b0);
    end
    wait_drained();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_before_start();
    test_version_error();
    test_count_error();
    test_single_entry();
    test_max_entries();
    test_random_headers(0, 0, 50);
    test_random_headers(73, 0, 50);
    test_random_headers(0, 73, 50);
    test_random_headers(30, 30, 50);
    wait_drained();
    repeat (20) @(posedge clk);
    if (pending_events.size() != 0) fail_cnt++;
    $display("tb: %0d headers, %0d parsed bytes, %0d events compared in %0d cycles",
             headers_sent, live_bytes, events_seen, cycle_cnt);
    $display("tb: size %0d, type %0d, char %0d, name end %0d, done %0d, error %0d",
             kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4],
             kind_seen[5]);
    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d failed checks", fail_cnt);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
